// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the calendar adjust RTL.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that cond holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
// Checks that trigger implies cons (cons may start with a fixed delay).
`define ASSERT_IMPLY(label, clk, rst, trigger, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trigger) |-> cons) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, trigger, cons)
`endif
`endif

// ----- rtl/tzc_pkg.sv -----
// Shared types, constants and calendar functions for the timezone adjust block.
// Depends on nothing; used by every module of the block.
`default_nettype none
package tzc_pkg;

  localparam logic [4:0] HOUR_MAX      = 5'd23;
  localparam logic signed [5:0] TZ_MAX = 6'sd23;
  localparam logic signed [5:0] TZ_MIN = -6'sd23;
  localparam logic signed [6:0] HOURS_PER_DAY = 7'sd24;
  localparam logic [6:0] YEAR_MOD      = 7'd100;
  localparam logic [6:0] YEAR_LAST     = 7'd99;
  localparam logic [3:0] MONTH_FIRST   = 4'd1;
  localparam logic [3:0] MONTH_LAST    = 4'd12;

  typedef struct packed {
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } tzc_rec_t;

  // Within 2000..2099 the century rule never removes a leap year, since
  // 2000 itself is divisible by 400.
  function automatic logic is_leap(input logic [6:0] yr2);
    return (yr2[1:0] == 2'd0);
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd2:    d = leap ? 5'd29 : 5'd28;
      4'd4:    d = 5'd30;
      4'd6:    d = 5'd30;
      4'd9:    d = 5'd30;
      4'd11:   d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/timezone_calendar_adjust.sv -----
// Top level of the timezone calendar adjust block: input and result registers.
// Depends on tzc_pkg, tzc_cfg_reg, tzc_adjust and assert_macros.svh.
//
// Each item taken on start passes the input register and then the result
// register, with done high for exactly one cycle; busy is always low, so an
// item may be started in every cycle and one result leaves per cycle. The
// adjust logic lies between the two registers. The receiver cannot stall: a
// result stays on the outputs until the next one replaces it; done marks its
// arrival. The offset register may be written only when no item is in flight.
`default_nettype none
`include "assert_macros.svh"
module timezone_calendar_adjust
  import tzc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic [5:0] cfg_data,
  output logic       cfg_ready,
  input  logic       start,
  output logic       busy,
  input  logic [5:0] in_seconds,
  input  logic [5:0] in_minutes,
  input  logic [4:0] in_hour,
  input  logic [4:0] in_day,
  input  logic [3:0] in_month,
  input  logic [6:0] in_year,
  output logic       done,
  output logic [5:0] out_seconds,
  output logic [5:0] out_minutes,
  output logic [4:0] out_hour,
  output logic [4:0] out_day,
  output logic [3:0] out_month,
  output logic [6:0] out_year
);

  logic signed [5:0] offset;
  logic              stage_valid;
  tzc_rec_t          stage_rec;
  tzc_rec_t          adj_rec;
  tzc_rec_t          result_rec;

  assign busy = 1'b0;

  tzc_cfg_reg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .offset    (offset)
  );

  tzc_adjust u_adjust (
    .rec_in  (stage_rec),
    .offset  (offset),
    .rec_out (adj_rec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      done        <= 1'b0;
    end else begin
      stage_valid <= start && !busy;
      done        <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      stage_rec <= '{seconds: in_seconds, minutes: in_minutes, hour: in_hour,
                     day: in_day, month: in_month, year: in_year};
    end
    if (stage_valid) begin
      result_rec <= adj_rec;
    end
  end

  assign out_seconds = result_rec.seconds;
  assign out_minutes = result_rec.minutes;
  assign out_hour    = result_rec.hour;
  assign out_day     = result_rec.day;
  assign out_month   = result_rec.month;
  assign out_year    = result_rec.year;

  `ASSERT_IMPLY(a_start_to_done, clk, rst, start && !busy, ##2 done)
  `ASSERT_IMPLY(a_hour_range, clk, rst, done, (out_hour <= HOUR_MAX))
  `ASSERT_IMPLY(a_month_range, clk, rst, done, (out_month >= MONTH_FIRST) && (out_month <= MONTH_LAST))
  `ASSERT_IMPLY(a_year_range, clk, rst, done, (out_year <= YEAR_LAST))

endmodule
`default_nettype wire

// ----- rtl/tzc_cfg_reg.sv -----
// Offset configuration register; clamps the written value to -23..23.
// Depends on tzc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module tzc_cfg_reg
  import tzc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic        [5:0] cfg_data,
  output logic              cfg_ready,
  output logic signed [5:0] offset
);

  logic signed [5:0] wr_value;
  logic signed [5:0] offset_next;

  assign cfg_ready = 1'b1;
  assign wr_value  = $signed(cfg_data);

  always_comb begin
    if (wr_value > TZ_MAX) begin
      offset_next = TZ_MAX;
    end else if (wr_value < TZ_MIN) begin
      offset_next = TZ_MIN;
    end else begin
      offset_next = wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      offset <= offset_next;
    end
  end

  `ASSERT_ALWAYS(a_offset_range, clk, rst, (offset <= TZ_MAX) && (offset >= TZ_MIN))

endmodule
`default_nettype wire

// ----- rtl/tzc_adjust.sv -----
// Combinational hour offset with one day carry or borrow through the calendar.
// Depends on tzc_pkg for the record type and month lengths.
`default_nettype none
module tzc_adjust
  import tzc_pkg::*;
(
  input  tzc_rec_t          rec_in,
  input  logic signed [5:0] offset,
  output tzc_rec_t          rec_out
);

  logic [4:0]        hour_c;
  logic [3:0]        month_c;
  logic [6:0]        year_c;
  logic signed [6:0] sum;
  logic              carry;
  logic              borrow;
  logic [5:0]        day_inc;
  logic [4:0]        dim_cur;
  logic [3:0]        month_prev;
  logic [6:0]        year_prev;
  logic [4:0]        dim_prev;
  logic signed [6:0] hour_adj;

  // Out-of-range hour and month are clamped and years above 99 wrap before use.
  assign hour_c  = (rec_in.hour > HOUR_MAX) ? HOUR_MAX : rec_in.hour;
  assign month_c = (rec_in.month < MONTH_FIRST) ? MONTH_FIRST :
                   (rec_in.month > MONTH_LAST) ? MONTH_LAST : rec_in.month;
  assign year_c  = (rec_in.year >= YEAR_MOD) ? (rec_in.year - YEAR_MOD) : rec_in.year;

  assign sum    = $signed({2'b00, hour_c}) + 7'(offset);
  assign carry  = (sum >= HOURS_PER_DAY);
  assign borrow = (sum < 7'sd0);

  assign day_inc    = {1'b0, rec_in.day} + 6'd1;
  assign dim_cur    = month_length(month_c, is_leap(year_c));
  assign month_prev = (month_c == MONTH_FIRST) ? MONTH_LAST : (month_c - 4'd1);
  assign year_prev  = (month_c != MONTH_FIRST) ? year_c :
                      (year_c == 7'd0) ? YEAR_LAST : (year_c - 7'd1);
  assign dim_prev   = month_length(month_prev, is_leap(year_prev));

  always_comb begin
    rec_out.seconds = rec_in.seconds;
    rec_out.minutes = rec_in.minutes;
    rec_out.day     = rec_in.day;
    rec_out.month   = month_c;
    rec_out.year    = year_c;
    hour_adj        = sum;
    if (carry) begin
      hour_adj = sum - HOURS_PER_DAY;
      if (day_inc > {1'b0, dim_cur}) begin
        rec_out.day = 5'd1;
        if (month_c == MONTH_LAST) begin
          rec_out.month = MONTH_FIRST;
          rec_out.year  = (year_c == YEAR_LAST) ? 7'd0 : (year_c + 7'd1);
        end else begin
          rec_out.month = month_c + 4'd1;
        end
      end else begin
        rec_out.day = day_inc[4:0];
      end
    end else if (borrow) begin
      hour_adj = sum + HOURS_PER_DAY;
      if (rec_in.day <= 5'd1) begin
        rec_out.day   = dim_prev;
        rec_out.month = month_prev;
        rec_out.year  = year_prev;
      end else begin
        rec_out.day = rec_in.day - 5'd1;
      end
    end
    rec_out.hour = hour_adj[4:0];
  end

endmodule
`default_nettype wire

// ----- dv/timezone_calendar_adjust_tb.sv -----
// Self-checking testbench for timezone_calendar_adjust: directed table, then random records.
// Depends on tzc_pkg for the record type and offset limits; needs only the RTL to run.
`default_nettype none
module timezone_calendar_adjust_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tzc_pkg::tzc_rec_t;
  import tzc_pkg::TZ_MAX;
  import tzc_pkg::TZ_MIN;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_CHUNKS = 7;
  localparam int CHUNK_ITEMS = 100;

  typedef struct {
    logic [5:0] offset;
    tzc_rec_t   stim;
    bit         typed;
    tzc_rec_t   want;
  } dir_row_t;

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic [5:0] cfg_data;
  logic       cfg_ready;
  logic       start;
  logic       busy;
  logic [5:0] in_seconds;
  logic [5:0] in_minutes;
  logic [4:0] in_hour;
  logic [4:0] in_day;
  logic [3:0] in_month;
  logic [6:0] in_year;
  logic       done;
  logic [5:0] out_seconds;
  logic [5:0] out_minutes;
  logic [4:0] out_hour;
  logic [4:0] out_day;
  logic [3:0] out_month;
  logic [6:0] out_year;

  tzc_rec_t   pending_dates[$];
  logic [5:0] offset_reg;
  int         gap_pct;
  int         mismatch_count;
  int         quiet_cycles;

  timezone_calendar_adjust uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .cfg_ready  (cfg_ready),
    .start      (start),
    .busy       (busy),
    .in_seconds (in_seconds),
    .in_minutes (in_minutes),
    .in_hour    (in_hour),
    .in_day     (in_day),
    .in_month   (in_month),
    .in_year    (in_year),
    .done       (done),
    .out_seconds(out_seconds),
    .out_minutes(out_minutes),
    .out_hour   (out_hour),
    .out_day    (out_day),
    .out_month  (out_month),
    .out_year   (out_year)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int month_days(input int mon, input int yr2);
    int yr_full;
    int days;
    yr_full = 2000 + yr2;
    case (mon)
      2: begin
        if (((yr_full % 4 == 0) && (yr_full % 100 != 0)) || (yr_full % 400 == 0))
          days = 29;
        else
          days = 28;
      end
      4, 6, 9, 11: days = 30;
      default: days = 31;
    endcase
    return days;
  endfunction

  // Local time for one record under the given raw offset register value.
  function automatic tzc_rec_t shift_to_local(input tzc_rec_t rec, input logic [5:0] off_raw);
    int off;
    int hr;
    int dy;
    int mon;
    int yr;
    tzc_rec_t res;
    off = $signed(off_raw);
    hr  = rec.hour;
    dy  = rec.day;
    mon = rec.month;
    yr  = rec.year % 100;
    if (off > 23) off = 23;
    if (off < -23) off = -23;
    if (hr > 23) hr = 23;
    if (mon < 1) mon = 1;
    if (mon > 12) mon = 12;
    hr = hr + off;
    if (hr >= 24) begin
      hr = hr - 24;
      dy = dy + 1;
      if (dy > month_days(mon, yr)) begin
        dy  = 1;
        mon = mon + 1;
        if (mon > 12) begin
          mon = 1;
          yr  = (yr + 1) % 100;
        end
      end
    end else if (hr < 0) begin
      hr = hr + 24;
      dy = dy - 1;
      if (dy < 1) begin
        mon = mon - 1;
        if (mon < 1) begin
          mon = 12;
          yr  = (yr + 99) % 100;
        end
        dy = month_days(mon, yr);
      end
    end
    res.seconds = rec.seconds;
    res.minutes = rec.minutes;
    res.hour    = 5'(hr);
    res.day     = 5'(dy);
    res.month   = 4'(mon);
    res.year    = 7'(yr);
    return res;
  endfunction

  function automatic dir_row_t mk_row(input logic [5:0] off, input int s, input int m,
                                      input int h, input int d, input int mo, input int y,
                                      input bit typed, input int eh, input int ed,
                                      input int emo, input int ey);
    dir_row_t row;
    row.offset = off;
    row.stim   = '{6'(s), 6'(m), 5'(h), 5'(d), 4'(mo), 7'(y)};
    row.typed  = typed;
    row.want   = '{6'(s), 6'(m), 5'(eh), 5'(ed), 4'(emo), 7'(ey)};
    return row;
  endfunction

  // Mostly legal dates leaning on month ends and midnight; some raw full-width records.
  function automatic tzc_rec_t random_record();
    tzc_rec_t rec;
    int len;
    if ($urandom_range(0, 9) < 2) begin
      rec.seconds = 6'($urandom_range(0, 63));
      rec.minutes = 6'($urandom_range(0, 63));
      rec.hour    = 5'($urandom_range(0, 31));
      rec.day     = 5'($urandom_range(0, 31));
      rec.month   = 4'($urandom_range(0, 15));
      rec.year    = 7'($urandom_range(0, 127));
    end else begin
      rec.seconds = 6'($urandom_range(0, 59));
      rec.minutes = 6'($urandom_range(0, 59));
      rec.year    = 7'($urandom_range(0, 99));
      rec.month   = 4'($urandom_range(1, 12));
      len = month_days(rec.month, rec.year);
      case ($urandom_range(0, 3))
        0: rec.day = 5'd1;
        1: rec.day = 5'(len);
        2: rec.day = 5'(len - 1);
        default: rec.day = 5'($urandom_range(1, len));
      endcase
      case ($urandom_range(0, 2))
        0: rec.hour = 5'($urandom_range(0, 3));
        1: rec.hour = 5'($urandom_range(20, 23));
        default: rec.hour = 5'($urandom_range(0, 23));
      endcase
    end
    return rec;
  endfunction

  task automatic drive_record(input tzc_rec_t rec, input bit typed, input tzc_rec_t want);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) >= gap_pct) break;
      start = 1'b0;
    end
    start      = 1'b1;
    in_seconds = rec.seconds;
    in_minutes = rec.minutes;
    in_hour    = rec.hour;
    in_day     = rec.day;
    in_month   = rec.month;
    in_year    = rec.year;
    do @(posedge clk); while (busy);
    if (typed)
      pending_dates.push_back(want);
    else
      pending_dates.push_back(shift_to_local(rec, offset_reg));
  endtask

  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // The offset may only change with nothing in flight, so drain first.
  task automatic write_offset(input logic [5:0] value);
    drain_results();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    offset_reg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(posedge clk) begin : result_check
    tzc_rec_t got;
    tzc_rec_t want;
    if (!rst && done) begin
      got = '{out_seconds, out_minutes, out_hour, out_day, out_month, out_year};
      if (pending_dates.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: result %p arrived with no item pending", got);
      end else begin
        want = pending_dates.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Watchdog: any handshake or result counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t dir_rows[$];
    tzc_rec_t none;
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    start          = 1'b0;
    in_seconds     = '0;
    in_minutes     = '0;
    in_hour        = '0;
    in_day         = '0;
    in_month       = '0;
    in_year        = '0;
    offset_reg     = '0;
    gap_pct        = 18;
    mismatch_count = 0;
    quiet_cycles   = 0;
    none           = '0;

    // Offset after reset is zero: records pass through; hour and month are clamped, years wrap.
    dir_rows.push_back(mk_row(6'd0, 0, 0, 0, 1, 1, 0, 1, 0, 1, 1, 0));
    dir_rows.push_back(mk_row(6'd0, 59, 59, 23, 31, 12, 99, 1, 23, 31, 12, 99));
    dir_rows.push_back(mk_row(6'd0, 63, 63, 31, 31, 15, 127, 1, 23, 31, 12, 27));
    // One hour forward: year wrap, February in common and leap years, the year 2000.
    dir_rows.push_back(mk_row(6'd1, 0, 0, 23, 31, 12, 99, 1, 0, 1, 1, 0));
    dir_rows.push_back(mk_row(6'd1, 10, 20, 23, 28, 2, 23, 1, 0, 1, 3, 23));
    dir_rows.push_back(mk_row(6'd1, 10, 20, 23, 28, 2, 24, 1, 0, 29, 2, 24));
    dir_rows.push_back(mk_row(6'd1, 5, 6, 23, 29, 2, 0, 1, 0, 1, 3, 0));
    // One hour back: borrows across year, into February, from day zero, month zero.
    dir_rows.push_back(mk_row(6'h3F, 0, 0, 0, 1, 1, 0, 1, 23, 31, 12, 99));
    dir_rows.push_back(mk_row(6'h3F, 0, 0, 0, 1, 3, 24, 1, 23, 29, 2, 24));
    dir_rows.push_back(mk_row(6'h3F, 0, 0, 0, 1, 3, 23, 1, 23, 28, 2, 23));
    dir_rows.push_back(mk_row(6'h3F, 0, 0, 0, 0, 5, 10, 1, 23, 30, 4, 10));
    dir_rows.push_back(mk_row(6'h3F, 0, 0, 5, 0, 5, 10, 1, 4, 0, 5, 10));
    dir_rows.push_back(mk_row(6'h3F, 0, 0, 0, 1, 0, 50, 1, 23, 31, 12, 49));
    // Largest positive register value saturates to +23; day past month end carries.
    dir_rows.push_back(mk_row(6'h1F, 0, 0, 1, 31, 4, 10, 1, 0, 1, 5, 10));
    dir_rows.push_back(mk_row(6'h1F, 0, 0, 0, 15, 6, 10, 1, 23, 15, 6, 10));
    dir_rows.push_back(mk_row(6'h1F, 0, 0, 31, 30, 4, 10, 1, 22, 1, 5, 10));
    // Most negative register value saturates to -23; year above 99 wraps first.
    dir_rows.push_back(mk_row(6'h20, 0, 0, 23, 5, 7, 60, 1, 0, 5, 7, 60));
    dir_rows.push_back(mk_row(6'h20, 0, 0, 22, 1, 1, 0, 1, 23, 31, 12, 99));
    dir_rows.push_back(mk_row(TZ_MAX, 0, 0, 0, 10, 8, 8, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(TZ_MAX, 0, 0, 12, 31, 1, 100, 1, 11, 1, 2, 0));
    dir_rows.push_back(mk_row(TZ_MIN, 0, 0, 11, 1, 3, 0, 1, 12, 29, 2, 0));
    dir_rows.push_back(mk_row(TZ_MIN, 0, 0, 23, 31, 2, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(TZ_MIN, 59, 0, 0, 31, 1, 99, 0, 0, 0, 0, 0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].offset != offset_reg)
        write_offset(dir_rows[i].offset);
      drive_record(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
      if (chunk < 2)
        gap_pct = 18;
      else if (chunk < 4)
        gap_pct = 45;
      else
        gap_pct = 0;
      case (chunk)
        0: write_offset(6'h20);
        1: write_offset(6'h1F);
        default: write_offset(6'($urandom_range(0, 63)));
      endcase
      for (int n = 0; n < CHUNK_ITEMS; n++)
        drive_record(random_record(), 1'b0, none);
    end

    drain_results();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0 && pending_dates.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire
